/* sv/dld_pkg.sv */
package dld_pkg;

  // Default maximum string length.
  localparam int MAX_LEN_DEF = 32;

  // Width and saturation value of the distance field.
  localparam int DIST_W = 6;
  localparam int DIST_MAX = 63;

  // Request commands.
  localparam logic [1:0] CMD_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] CMD_LOAD_SECOND = 2'd1;
  localparam logic [1:0] CMD_COMPUTE     = 2'd2;

  // One request: a command and a character byte.
  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } req_t;

  // One result: the edit distance and the dropped-character flag.
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } rsp_t;

endpackage

/* sv/dld_ram.sv */
module dld_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one read port with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* sv/dld_cell.sv */
module dld_cell #(
  parameter int DW = 6
) (
  input  logic [DW-1:0] up,
  input  logic [DW-1:0] left,
  input  logic [DW-1:0] diag,
  input  logic [DW-1:0] up2,
  input  logic [7:0]    a,
  input  logic [7:0]    b,
  input  logic [7:0]    a_prev,
  input  logic [7:0]    b_prev,
  input  logic          trans_ok,
  output logic [DW-1:0] min_cost
);

  logic [DW:0] del_cost;
  logic [DW:0] ins_cost;
  logic [DW:0] sub_cost;
  logic [DW:0] tra_cost;
  logic [DW:0] best_a;
  logic [DW:0] best_b;
  logic [DW:0] best_c;

  // Candidate costs, one bit wider so that the increment cannot wrap.
  assign del_cost = {1'b0, up} + (DW+1)'(1);
  assign ins_cost = {1'b0, left} + (DW+1)'(1);
  assign sub_cost = {1'b0, diag} + ((a != b) ? (DW+1)'(1) : (DW+1)'(0));
  assign tra_cost = {1'b0, up2} + (DW+1)'(1);

  // Minimum over the candidates; transposition only when the swapped pair matches.
  always_comb begin
    best_a = (del_cost < ins_cost) ? del_cost : ins_cost;
    best_b = (sub_cost < best_a) ? sub_cost : best_a;
    best_c = best_b;
    if (trans_ok && (a == b_prev) && (a_prev == b) && (tra_cost < best_b)) begin
      best_c = tra_cost;
    end
  end

  // The minimum never exceeds the longer string length, so it fits in DW bits.
  assign min_cost = best_c[DW-1:0];

endmodule

/* sv/damerau_levenshtein_distance.sv */
// Load requests are taken while idle and give no result.
// A compute request with both strings non-empty steps each row through S_ROW_RD and S_ROW_LD
// and each cell through S_CELL_RD and S_CELL_CALC, then S_FINISH; with an empty string it goes to S_FINISH.
// The single cell update unit handles one table cell per S_CELL_RD/S_CELL_CALC pair, paced by the
// registered read of the row memory; no request is taken while a compute is running.
// Reset clears both lengths, the overflow flag and the result valid; memories are not cleared.
module damerau_levenshtein_distance #(
  parameter int MAX_LEN = dld_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  dld_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output dld_pkg::rsp_t out_rsp
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW = (LW > dld_pkg::DIST_W) ? LW : dld_pkg::DIST_W;

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_ROW_RD    = 6'b000010,
    S_ROW_LD    = 6'b000100,
    S_CELL_RD   = 6'b001000,
    S_CELL_CALC = 6'b010000,
    S_FINISH    = 6'b100000
  } state_t;

  state_t        state_r, state_nxt;
  logic [LW-1:0] len1_r, len1_nxt;
  logic [LW-1:0] len2_r, len2_nxt;
  logic          drop_r, drop_nxt;
  logic          out_valid_r, out_valid_nxt;
  dld_pkg::rsp_t out_rsp_r, out_rsp_nxt;
  logic [LW-1:0] i_r, i_nxt;
  logic [LW-1:0] j_r, j_nxt;
  logic [7:0]    a_r, a_nxt;
  logic [7:0]    a_prev_r, a_prev_nxt;
  logic [7:0]    b_prev_r, b_prev_nxt;
  logic [LW-1:0] left_r, left_nxt;
  logic [LW-1:0] diag_r, diag_nxt;
  logic [LW-1:0] p1_r, p1_nxt;
  logic [LW-1:0] p2_r, p2_nxt;

  logic          in_acc;
  logic          first_wr;
  logic          second_wr;
  logic          row_wr;
  logic [LW-1:0] i_m1;
  logic [LW-1:0] j_m1;
  logic [7:0]    first_rd;
  logic [7:0]    second_rd;
  logic [2*LW-1:0] row_rd;
  logic [LW-1:0] up_val;
  logic [LW-1:0] up2_val;
  logic [LW-1:0] cell_dist;
  logic          trans_ok;
  logic [EW-1:0] left_ext;
  logic [dld_pkg::DIST_W-1:0] dist_sat;

  // Handshake: requests are taken only while idle.
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Appends go to the next free slot of the chosen string.
  assign first_wr  = in_acc && (in_req.cmd == dld_pkg::CMD_LOAD_FIRST)
                     && (len1_r < LW'(MAX_LEN));
  assign second_wr = in_acc && (in_req.cmd == dld_pkg::CMD_LOAD_SECOND)
                     && (len2_r < LW'(MAX_LEN));
  assign row_wr    = (state_r == S_CELL_CALC);
  assign i_m1      = i_r - LW'(1);
  assign j_m1      = j_r - LW'(1);

  dld_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_first_ram (
    .clk     (clk),
    .wr_en   (first_wr),
    .wr_addr (len1_r[AW-1:0]),
    .wr_data (in_req.ch),
    .rd_addr (i_m1[AW-1:0]),
    .rd_data (first_rd)
  );

  dld_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_second_ram (
    .clk     (clk),
    .wr_en   (second_wr),
    .wr_addr (len2_r[AW-1:0]),
    .wr_data (in_req.ch),
    .rd_addr (j_m1[AW-1:0]),
    .rd_data (second_rd)
  );

  // Each row word holds the column's value in the previous row (upper half)
  // and in the row before that (lower half).
  dld_ram #(.WIDTH(2*LW), .DEPTH(MAX_LEN)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_wr),
    .wr_addr (j_m1[AW-1:0]),
    .wr_data ({cell_dist, up_val}),
    .rd_addr (j_m1[AW-1:0]),
    .rd_data (row_rd)
  );

  // In the first row the row above is the column index itself.
  assign up_val   = (i_r == LW'(1)) ? j_r : row_rd[2*LW-1:LW];
  assign up2_val  = row_rd[LW-1:0];
  assign trans_ok = (i_r > LW'(1)) && (j_r > LW'(1));

  dld_cell #(.DW(LW)) u_cell (
    .up       (up_val),
    .left     (left_r),
    .diag     (diag_r),
    .up2      (p2_r),
    .a        (a_r),
    .b        (second_rd),
    .a_prev   (a_prev_r),
    .b_prev   (b_prev_r),
    .trans_ok (trans_ok),
    .min_cost (cell_dist)
  );

  // Saturate the distance to the output field width.
  assign left_ext = EW'(left_r);
  assign dist_sat = (left_ext > EW'(dld_pkg::DIST_MAX))
                    ? dld_pkg::DIST_W'(dld_pkg::DIST_MAX)
                    : left_ext[dld_pkg::DIST_W-1:0];

  // Sequencer: a row start through S_ROW_RD and S_ROW_LD, then S_CELL_RD and S_CELL_CALC for each cell.
  always_comb begin
    state_nxt     = state_r;
    len1_nxt      = len1_r;
    len2_nxt      = len2_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_rsp_nxt   = out_rsp_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    a_nxt         = a_r;
    a_prev_nxt    = a_prev_r;
    b_prev_nxt    = b_prev_r;
    left_nxt      = left_r;
    diag_nxt      = diag_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_req.cmd)
            dld_pkg::CMD_LOAD_FIRST: begin
              if (first_wr) begin
                len1_nxt = len1_r + LW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            dld_pkg::CMD_LOAD_SECOND: begin
              if (second_wr) begin
                len2_nxt = len2_r + LW'(1);
              end else begin
                drop_nxt = 1'b1;
              end
            end
            dld_pkg::CMD_COMPUTE: begin
              if ((len1_r == '0) || (len2_r == '0)) begin
                // With an empty string the distance is the other length.
                left_nxt  = len1_r | len2_r;
                state_nxt = S_FINISH;
              end else begin
                i_nxt     = LW'(1);
                state_nxt = S_ROW_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_ROW_RD: begin
        state_nxt = S_ROW_LD;
      end
      S_ROW_LD: begin
        // Column zero of rows i, i-1 and i-2 holds the row index.
        a_prev_nxt = a_r;
        a_nxt      = first_rd;
        j_nxt      = LW'(1);
        left_nxt   = i_r;
        diag_nxt   = i_r - LW'(1);
        p1_nxt     = i_r - LW'(2);
        state_nxt  = S_CELL_RD;
      end
      S_CELL_RD: begin
        state_nxt = S_CELL_CALC;
      end
      S_CELL_CALC: begin
        left_nxt   = cell_dist;
        diag_nxt   = up_val;
        p2_nxt     = p1_r;
        p1_nxt     = up2_val;
        b_prev_nxt = second_rd;
        if (j_r == len2_r) begin
          if (i_r == len1_r) begin
            state_nxt = S_FINISH;
          end else begin
            i_nxt     = i_r + LW'(1);
            state_nxt = S_ROW_RD;
          end
        end else begin
          j_nxt     = j_r + LW'(1);
          state_nxt = S_CELL_RD;
        end
      end
      S_FINISH: begin
        // Wait for the output register to be free, then clear both strings.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt        = 1'b1;
          out_rsp_nxt.distance = dist_sat;
          out_rsp_nxt.overflow = drop_r;
          len1_nxt             = '0;
          len2_nxt             = '0;
          drop_nxt             = 1'b0;
          state_nxt            = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len1_r      <= '0;
      len2_r      <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len1_r      <= len1_nxt;
      len2_r      <= len2_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    a_r       <= a_nxt;
    a_prev_r  <= a_prev_nxt;
    b_prev_r  <= b_prev_nxt;
    left_r    <= left_nxt;
    diag_r    <= diag_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
  end

endmodule

/* sim/damerau_levenshtein_distance_tb.sv */
module damerau_levenshtein_distance_tb;

  localparam int STR_MAX = dld_pkg::MAX_LEN_DEF;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int IDLE_PCT = 6;
  localparam int QUIET_FROM = 4000;
  localparam int QUIET_TO = 8000;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQS = 1200;

  // A staged request; the hold flag makes the sender wait for all results first.
  typedef struct {
    dld_pkg::req_t req;
    bit            hold;
  } staged_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  dld_pkg::req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  dld_pkg::rsp_t out_rsp;

  staged_req_t queued_requests[$];
  dld_pkg::rsp_t awaited_distances[$];
  logic req_taken = 1'b0;
  int cycle_count = 0;
  int error_count = 0;
  int reqs_taken = 0;
  int results_checked = 0;
  int overflow_results = 0;
  int longest_pair = 0;
  int load_reqs_queued = 0;

  // Shadow copy of the string store.
  logic [7:0] first_chars[STR_MAX];
  logic [7:0] second_chars[STR_MAX];
  int first_len = 0;
  int second_len = 0;
  bit lost_char = 1'b0;

  damerau_levenshtein_distance dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Full-table optimal string alignment distance of the shadow strings.
  function automatic int osa_cost();
    int grid[STR_MAX+1][STR_MAX+1];
    int best;
    int cand;
    for (int i = 0; i <= first_len; i++) grid[i][0] = i;
    for (int j = 0; j <= second_len; j++) grid[0][j] = j;
    for (int i = 1; i <= first_len; i++) begin
      for (int j = 1; j <= second_len; j++) begin
        best = grid[i-1][j] + 1;
        if (grid[i][j-1] + 1 < best) best = grid[i][j-1] + 1;
        cand = grid[i-1][j-1] + ((first_chars[i-1] != second_chars[j-1]) ? 1 : 0);
        if (cand < best) best = cand;
        if (i > 1 && j > 1 && first_chars[i-1] == second_chars[j-2] &&
            first_chars[i-2] == second_chars[j-1]) begin
          cand = grid[i-2][j-2] + 1;
          if (cand < best) best = cand;
        end
        grid[i][j] = best;
      end
    end
    return grid[first_len][second_len];
  endfunction

  // Applies one accepted request to the shadow strings and records any result due.
  function automatic void load_or_measure(dld_pkg::req_t r);
    dld_pkg::rsp_t due;
    int cost;
    case (r.cmd)
      dld_pkg::CMD_LOAD_FIRST: begin
        if (first_len < STR_MAX) begin
          first_chars[first_len] = r.ch;
          first_len++;
        end else begin
          lost_char = 1'b1;
        end
      end
      dld_pkg::CMD_LOAD_SECOND: begin
        if (second_len < STR_MAX) begin
          second_chars[second_len] = r.ch;
          second_len++;
        end else begin
          lost_char = 1'b1;
        end
      end
      dld_pkg::CMD_COMPUTE: begin
        cost = osa_cost();
        if (cost > dld_pkg::DIST_MAX) cost = dld_pkg::DIST_MAX;
        due.distance = dld_pkg::DIST_W'(cost);
        due.overflow = lost_char;
        awaited_distances.push_back(due);
        if (first_len + second_len > longest_pair) longest_pair = first_len + second_len;
        first_len = 0;
        second_len = 0;
        lost_char = 1'b0;
      end
      default: begin
        // The unused command leaves everything as it was.
      end
    endcase
  endfunction

  // Compares a delivered result with the oldest awaited one.
  function automatic void compare_distance(dld_pkg::rsp_t got);
    dld_pkg::rsp_t want;
    if (awaited_distances.size() == 0) begin
      $display("%0t: unexpected result distance=%0d overflow=%0b", $time,
               got.distance, got.overflow);
      error_count++;
      return;
    end
    want = awaited_distances.pop_front();
    results_checked++;
    if (got.overflow) overflow_results++;
    if (got.distance !== want.distance) begin
      $display("%0t: distance mismatch: expected %0d, got %0d", $time,
               want.distance, got.distance);
      error_count++;
    end
    if (got.overflow !== want.overflow) begin
      $display("%0t: overflow mismatch: expected %0b, got %0b", $time,
               want.overflow, got.overflow);
      error_count++;
    end
  endfunction

  function automatic bit idle_now();
    if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < IDLE_PCT;
  endfunction

  function automatic void queue_request(logic [1:0] cmd, logic [7:0] ch, bit hold);
    staged_req_t s;
    s.req.cmd = cmd;
    s.req.ch = ch;
    s.hold = hold;
    queued_requests.push_back(s);
    if (cmd != CMD_UNUSED) load_reqs_queued++;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 6);
    if (r < 97) return $urandom_range(7, 16);
    return $urandom_range(28, 35);
  endfunction

  // Queues one string pair, mostly an edited copy of the first, loaded in
  // random interleaving with the odd unused request, then a compute request.
  function automatic void add_string_pair(int len_a, int len_b, bit hold_first);
    logic [7:0] str_a[$];
    logic [7:0] str_b[$];
    logic [7:0] alphabet[3];
    logic [7:0] tmp;
    bit wide;
    bit hold;
    int ia;
    int ib;
    int pos;
    wide = ($urandom_range(0, 3) == 0);
    hold = hold_first;
    foreach (alphabet[k]) alphabet[k] = 8'($urandom_range(0, 255));
    for (int k = 0; k < len_a; k++)
      str_a.push_back(wide ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 2)]);
    if ($urandom_range(0, 2) != 0) begin
      str_b = str_a;
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(0, 3))
          0: if (str_b.size() >= 2) begin
            pos = $urandom_range(0, str_b.size() - 2);
            tmp = str_b[pos];
            str_b[pos] = str_b[pos+1];
            str_b[pos+1] = tmp;
          end
          1: if (str_b.size() > 0) begin
            str_b[$urandom_range(0, str_b.size() - 1)] = alphabet[$urandom_range(0, 2)];
          end
          2: if (str_b.size() > 0) begin
            str_b.delete($urandom_range(0, str_b.size() - 1));
          end
          default: begin
            str_b.insert($urandom_range(0, str_b.size()), alphabet[$urandom_range(0, 2)]);
          end
        endcase
      end
    end else begin
      for (int k = 0; k < len_b; k++)
        str_b.push_back(wide ? 8'($urandom_range(0, 255)) : alphabet[$urandom_range(0, 2)]);
    end
    ia = 0;
    ib = 0;
    while (ia < str_a.size() || ib < str_b.size()) begin
      if (!hold && $urandom_range(0, 19) == 0)
        queue_request(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
      if (ib >= str_b.size() || (ia < str_a.size() && $urandom_range(0, 1) == 1)) begin
        queue_request(dld_pkg::CMD_LOAD_FIRST, str_a[ia], hold);
        ia++;
      end else begin
        queue_request(dld_pkg::CMD_LOAD_SECOND, str_b[ib], hold);
        ib++;
      end
      hold = 1'b0;
    end
    queue_request(dld_pkg::CMD_COMPUTE, 8'($urandom_range(0, 255)), hold);
  endfunction

  // Sender: a request stays on the port, unchanged, until it is accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      out_stall <= idle_now();
      if (!in_valid || req_taken) begin
        if (queued_requests.size() == 0 || idle_now()) begin
          in_valid <= 1'b0;
        end else if (queued_requests[0].hold && awaited_distances.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_req <= queued_requests[0].req;
          in_valid <= 1'b1;
          void'(queued_requests.pop_front());
        end
      end
    end
  end

  // Monitor: results are checked before the request of the same edge is applied.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("damerau_levenshtein_distance regression: fail");
      $finish;
    end
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      if (out_valid && !out_stall) compare_distance(out_rsp);
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        load_or_measure(in_req);
        reqs_taken++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int pair_idx;
    // Both strings empty.
    queue_request(dld_pkg::CMD_COMPUTE, 8'h00, 1'b0);
    // Second string empty, extreme characters in the first.
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h00, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'hFF, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'hFF, 1'b0);
    // First string empty.
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h55, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'hAA, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h00, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'h5A, 1'b0);
    // The unused command must change nothing.
    queue_request(CMD_UNUSED, 8'hFF, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'hA5, 1'b0);
    // Adjacent transposition.
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h61, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h62, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h62, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h61, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'h00, 1'b0);
    // Identical single characters.
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h7F, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h7F, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'h80, 1'b0);
    // A transposition that cannot be reused: the restricted distance is three.
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h63, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_FIRST, 8'h61, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h61, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h62, 1'b0);
    queue_request(dld_pkg::CMD_LOAD_SECOND, 8'h63, 1'b0);
    queue_request(dld_pkg::CMD_COMPUTE, 8'h01, 1'b0);

    // Random pairs; the first overfills the first string, the second fills it, and some wait for a drain.
    load_reqs_queued = 0;
    pair_idx = 0;
    while (load_reqs_queued < RANDOM_REQS) begin
      if (pair_idx == 0) add_string_pair(35, 33, 1'b1);
      else if (pair_idx == 1) add_string_pair(32, 34, 1'b0);
      else add_string_pair(pick_length(), pick_length(), (pair_idx % 25) == 5);
      pair_idx++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (queued_requests.size() != 0 || in_valid) @(posedge clk);
    while (awaited_distances.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Accepted %0d requests over %0d string pairs; checked %0d results, %0d with overflow.",
             reqs_taken, pair_idx + 7, results_checked, overflow_results);
    $display("Longest combined string length measured: %0d characters; %0d mismatches.",
             longest_pair, error_count);
    if (error_count == 0) begin
      $display("damerau_levenshtein_distance regression: pass");
    end else begin
      $display("damerau_levenshtein_distance regression: fail");
    end
    $finish;
  end

endmodule
